// ===== src/bpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Balance point package
// Shared types and constants: register map, configuration fields, ASCII codes.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int CENTER_W    = 16;
    localparam int SHIFT_W     = 5;
    localparam int LEN_W       = 8;
    localparam int POS_W       = 20;
    localparam int POS_MAX     = 524287;
    localparam int N_CORNERS   = 4;
    localparam int FIELD_IDX_W = 3;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [FIELD_IDX_W-1:0] FIELD_LIMIT = FIELD_IDX_W'(N_CORNERS);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd500;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd300;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST    = 5'd13;
    localparam logic [LEN_W-1:0]    LEN_RST      = 8'd100;

    typedef enum logic [1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_AVG_SHIFT = 2'd2,
        REG_MAX_LEN   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [SHIFT_W-1:0]  average_shift;
        logic [LEN_W-1:0]    max_line_length;
    } t_cfg;

    typedef struct packed {
        logic line_end;
        logic ping;
    } t_evt;

endpackage

// ===== src/bpl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Balance point configuration registers
// APB register file for center position, averaging shift and line length.
// ----------------------------------------------------------------------------
module bpl_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpl_pkg::APB_AW-1:0] paddr,
    input  logic [bpl_pkg::APB_DW-1:0] pwdata,
    output logic [bpl_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output bpl_pkg::t_cfg              o_cfg
);
    import bpl_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x        <= CENTER_X_RST;
            r_cfg.center_y        <= CENTER_Y_RST;
            r_cfg.average_shift   <= SHIFT_RST;
            r_cfg.max_line_length <= LEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_X:  r_cfg.center_x        <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:  r_cfg.center_y        <= pwdata[CENTER_W-1:0];
                REG_AVG_SHIFT: r_cfg.average_shift   <= pwdata[SHIFT_W-1:0];
                REG_MAX_LEN:   r_cfg.max_line_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X:  prdata = APB_DW'(r_cfg.center_x);
            REG_CENTER_Y:  prdata = APB_DW'(r_cfg.center_y);
            REG_AVG_SHIFT: prdata = APB_DW'(r_cfg.average_shift);
            REG_MAX_LEN:   prdata = APB_DW'(r_cfg.max_line_length);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== src/bpl_parser.sv =====
// ----------------------------------------------------------------------------
// Balance point line parser
// Registers one byte, tracks the line, parses up to four signed decimals into
// the corner values and emits a line-end or ping event with the corners.
// ----------------------------------------------------------------------------
module bpl_parser #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bpl_pkg::t_cfg                           i_cfg,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [7:0]                              i_in_byte,
    output logic                                    o_evt_valid,
    input  logic                                    i_evt_stall,
    output bpl_pkg::t_evt                           o_evt,
    output logic [bpl_pkg::N_CORNERS-1:0][SAMPLE_BITS-1:0] o_corners
);
    import bpl_pkg::*;

    localparam int PW = SAMPLE_BITS + 1;
    localparam int AW = SAMPLE_BITS + 5;
    localparam logic [PW-1:0] CAP   = PW'(1) << (SAMPLE_BITS - 1);
    localparam logic [PW-1:0] CAPM1 = CAP - PW'(1);

    logic                   r0_vld;
    logic [7:0]             r0_byte;

    logic [LEN_W-1:0]       r_line_pos;
    logic [7:0]             r_first_char;
    logic [FIELD_IDX_W-1:0] r_fi;
    logic [PW-1:0]          r_pval;
    logic                   r_neg;
    logic                   r_digits;
    logic                   r_sign;
    logic                   r_stop;
    logic [N_CORNERS-1:0][SAMPLE_BITS-1:0] r_corner;

    logic                   r1_vld;
    t_evt                   r1_evt;
    logic [N_CORNERS-1:0][SAMPLE_BITS-1:0] r1_corner;

    logic                   s0_ready;
    logic                   s1_ready;
    logic                   consume;

    logic [7:0]             c;
    logic [7:0]             first;
    logic                   data_line;
    logic                   is_digit;
    logic                   is_space;
    logic                   is_sign;
    logic                   active;
    logic                   line_end;
    logic [AW-1:0]          acc;

    logic [FIELD_IDX_W-1:0] n_fi;
    logic [PW-1:0]          n_pval;
    logic                   n_neg;
    logic                   n_digits;
    logic                   n_sign;
    logic                   n_stop;
    logic                   commit_old;
    logic                   commit_end;
    logic                   wr_en;
    logic [PW-1:0]          sel_pv;
    logic                   sel_neg;
    logic [PW-1:0]          neg_pv;
    logic [SAMPLE_BITS-1:0] wr_val;
    logic [N_CORNERS-1:0][SAMPLE_BITS-1:0] n_corner;
    logic [LEN_W-1:0]       n_line_pos;
    logic [FIELD_IDX_W-1:0] n_fi_line;
    logic [PW-1:0]          n_pval_line;
    logic                   n_neg_line;
    logic                   n_digits_line;
    logic                   n_sign_line;
    logic                   n_stop_line;

    assign s1_ready   = !r1_vld || !i_evt_stall;
    assign s0_ready   = !r0_vld || s1_ready;
    assign o_in_stall = !s0_ready;
    assign consume    = r0_vld && s1_ready;

    assign c         = r0_byte;
    assign first     = (r_line_pos == '0) ? c : r_first_char;
    assign data_line = (first != CH_P);
    assign is_digit  = c inside {[CH_0:CH_9]};
    assign is_space  = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
    assign active    = data_line && !r_stop && (r_fi < FIELD_LIMIT);
    assign line_end  = (c == CH_NL) ||
                       ({1'b0, r_line_pos} + 9'd1 >= {1'b0, i_cfg.max_line_length});
    assign acc       = AW'({r_pval, 3'b000}) + AW'({r_pval, 1'b0}) + AW'(c[3:0]);

    always_comb begin
        n_fi       = r_fi;
        n_pval     = r_pval;
        n_neg      = r_neg;
        n_digits   = r_digits;
        n_sign     = r_sign;
        n_stop     = r_stop;
        commit_old = 1'b0;
        if (active) begin
            if (is_digit) begin
                n_pval   = (acc > AW'(CAP)) ? CAP : acc[PW-1:0];
                n_digits = 1'b1;
            end else if (is_space) begin
                if (r_digits) begin
                    commit_old = 1'b1;
                end else if (r_sign) begin
                    n_stop = 1'b1;
                end
            end else if (is_sign) begin
                if (r_digits) begin
                    commit_old = 1'b1;
                end else if (r_sign) begin
                    n_stop = 1'b1;
                end
            end else begin
                commit_old = r_digits;
                n_stop     = 1'b1;
            end
        end
        if (commit_old) begin
            n_fi     = r_fi + FIELD_IDX_W'(1);
            n_pval   = '0;
            n_neg    = 1'b0;
            n_digits = 1'b0;
            n_sign   = 1'b0;
        end
        if (active && is_sign && !n_stop && (n_fi < FIELD_LIMIT)) begin
            n_sign = 1'b1;
            n_neg  = (c == CH_MINUS);
        end

        commit_end = line_end && data_line && n_digits && !n_stop && (n_fi < FIELD_LIMIT);
        wr_en      = commit_old || commit_end;
        sel_pv     = commit_old ? r_pval : n_pval;
        sel_neg    = commit_old ? r_neg  : n_neg;
        neg_pv     = PW'(0) - sel_pv;
        if (sel_neg) begin
            wr_val = neg_pv[SAMPLE_BITS-1:0];
        end else if (sel_pv >= CAP) begin
            wr_val = CAPM1[SAMPLE_BITS-1:0];
        end else begin
            wr_val = sel_pv[SAMPLE_BITS-1:0];
        end

        n_corner = r_corner;
        if (wr_en) begin
            n_corner[r_fi[1:0]] = wr_val;
        end

        if (line_end) begin
            n_line_pos    = '0;
            n_fi_line     = '0;
            n_pval_line   = '0;
            n_neg_line    = 1'b0;
            n_digits_line = 1'b0;
            n_sign_line   = 1'b0;
            n_stop_line   = 1'b0;
        end else begin
            n_line_pos    = r_line_pos + LEN_W'(1);
            n_fi_line     = n_fi;
            n_pval_line   = n_pval;
            n_neg_line    = n_neg;
            n_digits_line = n_digits;
            n_sign_line   = n_sign;
            n_stop_line   = n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (s0_ready) begin
            r0_vld <= i_in_valid;
        end
        if (s0_ready && i_in_valid) begin
            r0_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos   <= '0;
            r_first_char <= '0;
            r_fi         <= '0;
            r_pval       <= '0;
            r_neg        <= 1'b0;
            r_digits     <= 1'b0;
            r_sign       <= 1'b0;
            r_stop       <= 1'b0;
            r_corner     <= '0;
        end else if (consume) begin
            r_line_pos   <= n_line_pos;
            r_first_char <= first;
            r_fi         <= n_fi_line;
            r_pval       <= n_pval_line;
            r_neg        <= n_neg_line;
            r_digits     <= n_digits_line;
            r_sign       <= n_sign_line;
            r_stop       <= n_stop_line;
            r_corner     <= n_corner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (s1_ready) begin
            r1_vld <= consume && ((line_end && data_line) || (c == CH_P));
        end
        if (consume) begin
            r1_evt.line_end <= line_end && data_line;
            r1_evt.ping     <= (c == CH_P);
            r1_corner       <= n_corner;
        end
    end

    assign o_evt_valid = r1_vld;
    assign o_evt       = r1_evt;
    assign o_corners   = r1_corner;

endmodule

// ===== src/bpl_baseline.sv =====
// ----------------------------------------------------------------------------
// Balance point baseline tracker
// Updates the four corner baselines at each data line end and forms the
// horizontal and vertical deviation sums.
// ----------------------------------------------------------------------------
module bpl_baseline #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bpl_pkg::t_cfg                           i_cfg,
    input  logic                                    i_evt_valid,
    output logic                                    o_evt_stall,
    input  bpl_pkg::t_evt                           i_evt,
    input  logic [bpl_pkg::N_CORNERS-1:0][SAMPLE_BITS-1:0] i_corners,
    output logic                                    o_sum_valid,
    input  logic                                    i_sum_stall,
    output bpl_pkg::t_evt                           o_evt,
    output logic signed [SAMPLE_BITS+FRACTION_BITS+2:0] o_sum_x,
    output logic signed [SAMPLE_BITS+FRACTION_BITS+2:0] o_sum_y
);
    import bpl_pkg::*;

    localparam int BW = SAMPLE_BITS + FRACTION_BITS;
    localparam int DW = BW + 1;
    localparam int SW = BW + 3;

    logic [BW-1:0]        r_base [N_CORNERS];
    logic                 r_first;

    logic                 r2_vld;
    t_evt                 r2_evt;
    logic [BW-1:0]        r2_fx  [N_CORNERS];

    logic                 r3_vld;
    t_evt                 r3_evt;
    logic signed [SW-1:0] r3_sum_x;
    logic signed [SW-1:0] r3_sum_y;

    logic                 s2_ready;
    logic                 s3_ready;
    logic                 take;
    logic                 advance;

    logic [BW-1:0]        fx     [N_CORNERS];
    logic signed [BW:0]   diff   [N_CORNERS];
    logic signed [BW:0]   step   [N_CORNERS];
    logic [BW-1:0]        n_base [N_CORNERS];
    logic signed [DW-1:0] dev    [N_CORNERS];
    logic signed [SW-1:0] n_sum_x;
    logic signed [SW-1:0] n_sum_y;

    assign s3_ready    = !r3_vld || !i_sum_stall;
    assign s2_ready    = !r2_vld || s3_ready;
    assign o_evt_stall = !s2_ready;
    assign take        = i_evt_valid && s2_ready;
    assign advance     = r2_vld && s3_ready;

    always_comb begin
        for (int k = 0; k < N_CORNERS; k++) begin
            fx[k]     = {i_corners[k], {FRACTION_BITS{1'b0}}};
            diff[k]   = $signed({fx[k][BW-1], fx[k]}) - $signed({r_base[k][BW-1], r_base[k]});
            step[k]   = diff[k] >>> i_cfg.average_shift;
            n_base[k] = r_first ? fx[k] : (r_base[k] + step[k][BW-1:0]);
            dev[k]    = $signed({r2_fx[k][BW-1], r2_fx[k]})
                        - $signed({r_base[k][BW-1], r_base[k]});
        end
        n_sum_x = (SW'(dev[0]) - SW'(dev[1])) + (SW'(dev[2]) - SW'(dev[3]));
        n_sum_y = (SW'(dev[2]) - SW'(dev[0])) + (SW'(dev[3]) - SW'(dev[1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            for (int k = 0; k < N_CORNERS; k++) begin
                r_base[k] <= '0;
            end
        end else if (take && i_evt.line_end) begin
            r_first <= 1'b0;
            for (int k = 0; k < N_CORNERS; k++) begin
                r_base[k] <= n_base[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (s2_ready) begin
            r2_vld <= i_evt_valid;
        end
        if (take) begin
            r2_evt <= i_evt;
            for (int k = 0; k < N_CORNERS; k++) begin
                r2_fx[k] <= fx[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (s3_ready) begin
            r3_vld <= r2_vld;
        end
        if (advance) begin
            r3_evt   <= r2_evt;
            r3_sum_x <= n_sum_x;
            r3_sum_y <= n_sum_y;
        end
    end

    assign o_sum_valid = r3_vld;
    assign o_evt       = r3_evt;
    assign o_sum_x     = r3_sum_x;
    assign o_sum_y     = r3_sum_y;

endmodule

// ===== src/bpl_position.sv =====
// ----------------------------------------------------------------------------
// Balance point position stage
// Subtracts the deviation sums from the center, rounds half up, saturates to
// 20 bits and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module bpl_position #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bpl_pkg::t_cfg                               i_cfg,
    input  logic                                        i_sum_valid,
    output logic                                        o_sum_stall,
    input  bpl_pkg::t_evt                               i_evt,
    input  logic signed [SAMPLE_BITS+FRACTION_BITS+2:0] i_sum_x,
    input  logic signed [SAMPLE_BITS+FRACTION_BITS+2:0] i_sum_y,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic                                        o_position_valid,
    output logic signed [bpl_pkg::POS_W-1:0]            o_pos_x,
    output logic signed [bpl_pkg::POS_W-1:0]            o_pos_y,
    output logic                                        o_ping_seen
);
    import bpl_pkg::*;

    localparam int RW = (SAMPLE_BITS + 4 > POS_W + 1) ? SAMPLE_BITS + 4 : POS_W + 1;
    localparam int FW = RW + FRACTION_BITS;
    localparam logic signed [FW-1:0] HALF = FW'(1) << (FRACTION_BITS - 1);
    localparam logic signed [RW-1:0] PMAX = RW'(POS_MAX);
    localparam logic signed [RW-1:0] PMIN = ~PMAX;

    logic                    r_vld;
    logic                    r_pos_valid;
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic                    r_ping;

    logic                    ready;
    logic signed [FW-1:0]    cx_f;
    logic signed [FW-1:0]    cy_f;
    logic signed [FW-1:0]    fx;
    logic signed [FW-1:0]    fy;
    logic signed [RW-1:0]    rx;
    logic signed [RW-1:0]    ry;
    logic [POS_W-1:0]        sat_x;
    logic [POS_W-1:0]        sat_y;

    assign ready       = !r_vld || !i_out_stall;
    assign o_sum_stall = !ready;

    always_comb begin
        cx_f = $signed(FW'({i_cfg.center_x, {FRACTION_BITS{1'b0}}}));
        cy_f = $signed(FW'({i_cfg.center_y, {FRACTION_BITS{1'b0}}}));
        fx   = cx_f - FW'(i_sum_x) + HALF;
        fy   = cy_f - FW'(i_sum_y) + HALF;
        rx   = fx[FW-1:FRACTION_BITS];
        ry   = fy[FW-1:FRACTION_BITS];
        if (rx > PMAX) begin
            sat_x = PMAX[POS_W-1:0];
        end else if (rx < PMIN) begin
            sat_x = PMIN[POS_W-1:0];
        end else begin
            sat_x = rx[POS_W-1:0];
        end
        if (ry > PMAX) begin
            sat_y = PMAX[POS_W-1:0];
        end else if (ry < PMIN) begin
            sat_y = PMIN[POS_W-1:0];
        end else begin
            sat_y = ry[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (ready) begin
            r_vld <= i_sum_valid;
        end
        if (ready && i_sum_valid) begin
            r_pos_valid <= i_evt.line_end;
            r_ping      <= i_evt.ping;
            r_pos_x     <= i_evt.line_end ? sat_x : '0;
            r_pos_y     <= i_evt.line_end ? sat_y : '0;
        end
    end

    assign o_out_valid      = r_vld;
    assign o_position_valid = r_pos_valid;
    assign o_pos_x          = r_pos_x;
    assign o_pos_y          = r_pos_y;
    assign o_ping_seen      = r_ping;

endmodule

// ===== src/balance_point_from_load_cells_unit.sv =====
// ----------------------------------------------------------------------------
// Balance point from load cells
// Parses serial lines of four load-cell readings, tracks their baselines and
// outputs the rounded balance point on every data line.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, with no gaps between beats, until
// back-pressure from a stalled output reaches the input. A byte passes
// five register stages (input, parser, baseline update, deviation sums,
// position output) before its result beat appears; bytes that end no
// data line and are not 'p' produce no beat. The baseline update loop (one
// subtract, an arithmetic shift and one add per corner) sets the clock.
// A stalled output holds its beat while empty stages keep taking bytes.
// SAMPLE_BITS (8 to 32) sets the corner width, FRACTION_BITS (16 to 32) the
// baseline fraction.
module balance_point_from_load_cells_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpl_pkg::APB_AW-1:0]       paddr,
    input  logic [bpl_pkg::APB_DW-1:0]       pwdata,
    output logic [bpl_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_position_valid,
    output logic signed [bpl_pkg::POS_W-1:0] o_pos_x,
    output logic signed [bpl_pkg::POS_W-1:0] o_pos_y,
    output logic                             o_ping_seen
);
    import bpl_pkg::*;

    localparam int SW = SAMPLE_BITS + FRACTION_BITS + 3;

    t_cfg                  cfg;
    logic                  evt_valid;
    logic                  evt_stall;
    t_evt                  evt;
    logic [N_CORNERS-1:0][SAMPLE_BITS-1:0] corners;
    logic                  sum_valid;
    logic                  sum_stall;
    t_evt                  sum_evt;
    logic signed [SW-1:0]  sum_x;
    logic signed [SW-1:0]  sum_y;

    bpl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpl_parser #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_rx_byte),
        .o_evt_valid (evt_valid),
        .i_evt_stall (evt_stall),
        .o_evt       (evt),
        .o_corners   (corners)
    );

    bpl_baseline #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_baseline (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_evt_valid (evt_valid),
        .o_evt_stall (evt_stall),
        .i_evt       (evt),
        .i_corners   (corners),
        .o_sum_valid (sum_valid),
        .i_sum_stall (sum_stall),
        .o_evt       (sum_evt),
        .o_sum_x     (sum_x),
        .o_sum_y     (sum_y)
    );

    bpl_position #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_position (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_sum_valid      (sum_valid),
        .o_sum_stall      (sum_stall),
        .i_evt            (sum_evt),
        .i_sum_x          (sum_x),
        .i_sum_y          (sum_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_position_valid (o_position_valid),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_ping_seen      (o_ping_seen)
    );

endmodule

// ===== src/bpl_checker.sv =====
// ----------------------------------------------------------------------------
// Balance point port checker
// Concurrent checks on the result channel and reset state, bound to the top level.
// ----------------------------------------------------------------------------
module bpl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_position_valid,
    input logic signed [bpl_pkg::POS_W-1:0] o_pos_x,
    input logic signed [bpl_pkg::POS_W-1:0] o_pos_y,
    input logic                             o_ping_seen
);

    a_beat_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position_valid || o_ping_seen))
        else $error("result beat with neither position nor ping");

    a_ping_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_position_valid) |-> (o_pos_x == '0 && o_pos_y == '0))
        else $error("ping-only beat carries a nonzero position");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pos_x) &&
        $stable(o_pos_y) && $stable(o_position_valid) && $stable(o_ping_seen)))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");

endmodule

bind balance_point_from_load_cells_unit bpl_checker u_bpl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_position_valid (o_position_valid),
    .o_pos_x          (o_pos_x),
    .o_pos_y          (o_pos_y),
    .o_ping_seen      (o_ping_seen)
);
